FILE: design/csc_pkg.sv
// Shared constants, codes and types for the circle / polygon-edge contact test.
// Used by csc_store, csc_geom and circle_segment_collision; depends on nothing.
`default_nettype none

package csc_pkg;

	localparam int FRAC_BITS    = 8;
	localparam int MAX_CLUSTERS = 16;
	localparam int MAX_NODES    = 64;

	localparam int CL_W    = $clog2(MAX_CLUSTERS);
	localparam int ND_W    = $clog2(MAX_NODES);
	localparam int CNT_W   = $clog2(MAX_NODES + 1);
	localparam int ADDR_W  = CL_W + ND_W;
	localparam int DEPTH   = MAX_CLUSTERS * MAX_NODES;

	localparam int VTX_W   = 24;
	localparam int VREC_W  = 2 * VTX_W;
	localparam int CIR_W   = 16;
	localparam int RAD_W   = 15;
	localparam int CEN_W   = CIR_W + FRAC_BITS;

	// arithmetic widths
	localparam int CRD_W   = (VTX_W > CEN_W) ? VTX_W : CEN_W;
	localparam int DIF_W   = CRD_W + 1;
	localparam int MUL_W   = DIF_W + 1;
	localparam int PRD_W   = 2 * MUL_W;
	localparam int LIMB_W  = DIF_W;
	localparam int SQ_W    = 2 * DIF_W;
	localparam int PP_W    = 2 * DIF_W + 1;
	localparam int CR_W    = 2 * DIF_W + 1;
	localparam int CRH_W   = CR_W - LIMB_W;
	localparam int DDH_W   = SQ_W - LIMB_W;
	localparam int RSQ_W   = 2 * RAD_W;
	localparam int RSQH_W  = RSQ_W - LIMB_W;
	localparam int R2_W    = RSQ_W + 2 * FRAC_BITS;
	localparam int ACC_A_W = 2 * CR_W;
	localparam int ACC_B_W = RSQ_W + SQ_W + 2 * FRAC_BITS;
	localparam int ACC_W   = ((ACC_A_W > ACC_B_W) ? ACC_A_W : ACC_B_W) + 1;

	// request codes
	localparam logic [1:0] REQ_WR_VTX  = 2'd0;
	localparam logic [1:0] REQ_SET_CNT = 2'd1;
	localparam logic [1:0] REQ_QUERY   = 2'd2;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [VREC_W-1:0] wdata;
	} vtx_req_t;

	typedef struct packed {
		logic             we;
		logic [CL_W-1:0]  cl;
		logic [CNT_W-1:0] val;
	} cnt_wr_t;

	typedef struct packed {
		logic                    start;
		logic signed [VTX_W-1:0] x1;
		logic signed [VTX_W-1:0] y1;
		logic signed [VTX_W-1:0] x2;
		logic signed [VTX_W-1:0] y2;
		logic signed [CIR_W-1:0] cx;
		logic signed [CIR_W-1:0] cy;
		logic [RAD_W-1:0]        r;
	} geo_req_t;

	typedef struct packed {
		logic valid;
		logic hit;
	} geo_res_t;

endpackage

`default_nettype wire

FILE: design/circle_segment_collision.sv
// Top level: command port, request sequencing, vertex fetch and result register.
// Depends on csc_pkg, csc_store and csc_geom.
// Vertex writes, count settings, unknown requests and queries on a node at or past
// the cluster count: done the cycle after acceptance, busy stays low.
// Edge queries: done after vertex fetch and geometry result, busy high in between; the two
// vertex reads share the single memory port and the shared multiply-accumulate runs 19 steps.
// Reset clears the vertex counts; the vertex memory holds no value until written.
`default_nettype none

module circle_segment_collision (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [1:0]                         req_type,
	input  wire logic [3:0]                         poly_id,
	input  wire logic [5:0]                         node_id,
	input  wire logic signed [23:0]                 vertex_x,
	input  wire logic signed [23:0]                 vertex_y,
	input  wire logic [6:0]                         node_count,
	input  wire logic signed [15:0]                 circle_x,
	input  wire logic signed [15:0]                 circle_y,
	input  wire logic [14:0]                        circle_radius,
	output logic                                    done,
	output logic                                    hit,
	output logic                                    status
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD1  = 5'b00010,
		ST_RD2  = 5'b00100,
		ST_LDG  = 5'b01000,
		ST_CALC = 5'b10000
	} state_t;

	state_t state_q;

	logic acc, is_query, node_ok;
	logic [csc_pkg::CNT_W-1:0] cnt_rd, node_inc;
	logic [csc_pkg::ND_W-1:0]  n2;

	csc_pkg::vtx_req_t          vreq;
	logic [csc_pkg::VREC_W-1:0] vrdata;
	csc_pkg::cnt_wr_t           cwr;
	csc_pkg::geo_req_t          geo_req;
	csc_pkg::geo_res_t          geo_res;

	logic [csc_pkg::CL_W-1:0]         cl_q;
	logic [csc_pkg::ND_W-1:0]         node_q, n2_q;
	logic signed [csc_pkg::CIR_W-1:0] cx_q, cy_q;
	logic [csc_pkg::RAD_W-1:0]        r_q;
	logic signed [csc_pkg::VTX_W-1:0] x1_q, y1_q;
	logic                             done_q, hit_q, status_q;

	assign busy     = (state_q != ST_IDLE);
	assign acc      = start && !busy;
	assign is_query = (req_type == csc_pkg::REQ_QUERY);
	assign node_ok  = (csc_pkg::CNT_W'(node_id) < cnt_rd);
	assign node_inc = csc_pkg::CNT_W'(node_id) + csc_pkg::CNT_W'(1);
	// the edge wraps back to vertex 0 after the last one
	assign n2       = (node_inc >= cnt_rd) ? '0 : node_inc[csc_pkg::ND_W-1:0];

	assign cwr.we  = acc && (req_type == csc_pkg::REQ_SET_CNT);
	assign cwr.cl  = poly_id;
	assign cwr.val = node_count;

	always_comb begin
		vreq = '{en: 1'b0, we: 1'b0, addr: '0, wdata: '0};
		unique case (state_q)
			ST_IDLE: begin
				vreq.en    = acc && (req_type == csc_pkg::REQ_WR_VTX);
				vreq.we    = 1'b1;
				vreq.addr  = {poly_id, node_id};
				vreq.wdata = {vertex_x, vertex_y};
			end
			ST_RD1: begin
				vreq.en   = 1'b1;
				vreq.addr = {cl_q, node_q};
			end
			ST_RD2: begin
				vreq.en   = 1'b1;
				vreq.addr = {cl_q, n2_q};
			end
			ST_LDG, ST_CALC: vreq.en = 1'b0;
			default: vreq.en = 1'b0;
		endcase
	end

	csc_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.vreq    (vreq),
		.vrdata  (vrdata),
		.cwr     (cwr),
		.crd_cl  (poly_id),
		.crd_cnt (cnt_rd)
	);

	assign geo_req.start = (state_q == ST_LDG);
	assign geo_req.x1    = x1_q;
	assign geo_req.y1    = y1_q;
	assign geo_req.x2    = vrdata[csc_pkg::VREC_W-1:csc_pkg::VTX_W];
	assign geo_req.y2    = vrdata[csc_pkg::VTX_W-1:0];
	assign geo_req.cx    = cx_q;
	assign geo_req.cy    = cy_q;
	assign geo_req.r     = r_q;

	csc_geom u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (geo_req),
		.res    (geo_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			hit_q    <= 1'b0;
			status_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (is_query && node_ok) begin
							state_q <= ST_RD1;
						end else begin
							done_q   <= 1'b1;
							hit_q    <= 1'b0;
							status_q <= is_query;
						end
					end
				end
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: state_q <= ST_LDG;
				ST_LDG: state_q <= ST_CALC;
				ST_CALC: begin
					if (geo_res.valid) begin
						done_q   <= 1'b1;
						hit_q    <= geo_res.hit;
						status_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cl_q   <= poly_id;
			node_q <= node_id;
			n2_q   <= n2;
			cx_q   <= circle_x;
			cy_q   <= circle_y;
			r_q    <= circle_radius;
		end
		// first vertex word lands while the second read is issued
		if (state_q == ST_RD2) begin
			x1_q <= vrdata[csc_pkg::VREC_W-1:csc_pkg::VTX_W];
			y1_q <= vrdata[csc_pkg::VTX_W-1:0];
		end
	end

	assign done   = done_q;
	assign hit    = hit_q;
	assign status = status_q;

	a_rd_window: assert property (@(posedge clk) disable iff (!arst_n)
		(vreq.en && !vreq.we) |-> (state_q == ST_RD1 || state_q == ST_RD2))
		else $error("vertex read outside fetch states");

	a_res_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		geo_res.valid |-> (state_q == ST_CALC))
		else $error("geometry result outside calc state");

	a_load_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req_type == csc_pkg::REQ_WR_VTX) |=> (done && !hit && !status))
		else $error("vertex write word not acknowledged next cycle");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_query && node_ok) |=> (busy && !done))
		else $error("edge query did not enter fetch");

	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> !status)
		else $error("hit reported with bad node status");

endmodule

`default_nettype wire

FILE: design/csc_store.sv
// Vertex memory (single port, registered read) and per-cluster vertex counts.
// Depends on csc_pkg.
`default_nettype none

module csc_store (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire csc_pkg::vtx_req_t             vreq,
	output logic [csc_pkg::VREC_W-1:0]         vrdata,
	input  wire csc_pkg::cnt_wr_t              cwr,
	input  wire logic [csc_pkg::CL_W-1:0]      crd_cl,
	output logic [csc_pkg::CNT_W-1:0]          crd_cnt
);

	logic [csc_pkg::VREC_W-1:0] vmem [csc_pkg::DEPTH];
	logic [csc_pkg::VREC_W-1:0] rdata_q;
	logic [csc_pkg::CNT_W-1:0]  cnt_q [csc_pkg::MAX_CLUSTERS];
	logic [csc_pkg::CNT_W-1:0]  cnt_sat;

	// no reset on the vertex array: entries are undefined until written
	always_ff @(posedge clk) begin
		if (vreq.en) begin
			if (vreq.we)
				vmem[vreq.addr] <= vreq.wdata;
			else
				rdata_q <= vmem[vreq.addr];
		end
	end

	assign vrdata = rdata_q;

	assign cnt_sat = (cwr.val > csc_pkg::CNT_W'(csc_pkg::MAX_NODES)) ?
		csc_pkg::CNT_W'(csc_pkg::MAX_NODES) : cwr.val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < csc_pkg::MAX_CLUSTERS; i++)
				cnt_q[i] <= '0;
		end else if (cwr.we) begin
			cnt_q[cwr.cl] <= cnt_sat;
		end
	end

	assign crd_cnt = cnt_q[crd_cl];

endmodule

`default_nettype wire

FILE: design/csc_geom.sv
// Exact fixed-point circle versus segment test on one shared multiply-accumulate
// unit, stepped by a small sequencer. Wide squares are built from limb products.
// Depends on csc_pkg.
`default_nettype none

module csc_geom (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire csc_pkg::geo_req_t req,
	output csc_pkg::geo_res_t      res
);

	localparam int STEP_W = 5;
	localparam int CMP_W  = (csc_pkg::SQ_W > csc_pkg::R2_W) ? csc_pkg::SQ_W : csc_pkg::R2_W;
	localparam int LW     = csc_pkg::LIMB_W;
	localparam int F2     = 2 * csc_pkg::FRAC_BITS;

	localparam logic [STEP_W-1:0] S_RSQ = 5'd0;
	localparam logic [STEP_W-1:0] S_CR0 = 5'd1;
	localparam logic [STEP_W-1:0] S_CR1 = 5'd2;
	localparam logic [STEP_W-1:0] S_DD0 = 5'd3;
	localparam logic [STEP_W-1:0] S_DD1 = 5'd4;
	localparam logic [STEP_W-1:0] S_PP0 = 5'd5;
	localparam logic [STEP_W-1:0] S_PP1 = 5'd6;
	localparam logic [STEP_W-1:0] S_E10 = 5'd7;
	localparam logic [STEP_W-1:0] S_E11 = 5'd8;
	localparam logic [STEP_W-1:0] S_E20 = 5'd9;
	localparam logic [STEP_W-1:0] S_E21 = 5'd10;
	localparam logic [STEP_W-1:0] S_Q0  = 5'd11;
	localparam logic [STEP_W-1:0] S_Q1  = 5'd12;
	localparam logic [STEP_W-1:0] S_Q2  = 5'd13;
	localparam logic [STEP_W-1:0] S_Q3  = 5'd14;
	localparam logic [STEP_W-1:0] S_M0  = 5'd15;
	localparam logic [STEP_W-1:0] S_M1  = 5'd16;
	localparam logic [STEP_W-1:0] S_M2  = 5'd17;
	localparam logic [STEP_W-1:0] S_M3  = 5'd18;

	typedef enum logic [2:0] {SH_0, SH_L, SH_2L, SH_F, SH_LF, SH_2LF} shift_t;
	typedef enum logic [2:0] {SV_NONE, SV_RSQ, SV_CR, SV_DD, SV_PP, SV_E1, SV_E2} save_t;

	typedef struct packed {
		logic   vld;
		logic   clr;
		logic   sub;
		shift_t sh;
		save_t  sv;
		logic   last;
	} mac_ctl_t;

	function automatic logic signed [csc_pkg::MUL_W-1:0] sx(
		input logic signed [csc_pkg::DIF_W-1:0] v);
		return csc_pkg::MUL_W'(v);
	endfunction

	function automatic logic signed [csc_pkg::MUL_W-1:0] zl(input logic [LW-1:0] v);
		return $signed({{(csc_pkg::MUL_W-LW){1'b0}}, v});
	endfunction

	// sequencer
	logic              run_q;
	logic [STEP_W-1:0] step_q;

	// operands
	logic signed [csc_pkg::DIF_W-1:0] dx_q, dy_q, fx_q, fy_q, gx_q, gy_q;
	logic [csc_pkg::RAD_W-1:0]        r_q;
	logic signed [csc_pkg::CEN_W-1:0] cx_w, cy_w;

	// saved partial results
	logic [csc_pkg::RSQ_W-1:0]        rsq_q;
	logic [csc_pkg::SQ_W-1:0]         dd_q, e1_q, e2_q;
	logic signed [csc_pkg::PP_W-1:0]  pp_q;
	logic signed [csc_pkg::CR_W-1:0]  cr_q;

	// mac pipe
	logic signed [csc_pkg::MUL_W-1:0] op_a, op_b;
	mac_ctl_t                         ctl_d, ctl_s1;
	logic signed [csc_pkg::PRD_W-1:0] prod_s1;
	logic signed [csc_pkg::ACC_W-1:0] prod_ext, shifted, base, acc_d, acc_q;
	logic                             dec_q;

	// decision
	logic [csc_pkg::R2_W-1:0] r2;
	logic dd_zero, pp_le0, dd_le_pp, near1, near2, mid_ok;

	assign cx_w = {req.cx, {csc_pkg::FRAC_BITS{1'b0}}};
	assign cy_w = {req.cy, {csc_pkg::FRAC_BITS{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			run_q  <= 1'b1;
			step_q <= '0;
		end else if (run_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == S_M3)
				run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dx_q <= csc_pkg::DIF_W'($signed(req.x2)) - csc_pkg::DIF_W'($signed(req.x1));
			dy_q <= csc_pkg::DIF_W'($signed(req.y2)) - csc_pkg::DIF_W'($signed(req.y1));
			fx_q <= csc_pkg::DIF_W'(cx_w) - csc_pkg::DIF_W'($signed(req.x1));
			fy_q <= csc_pkg::DIF_W'(cy_w) - csc_pkg::DIF_W'($signed(req.y1));
			gx_q <= csc_pkg::DIF_W'(cx_w) - csc_pkg::DIF_W'($signed(req.x2));
			gy_q <= csc_pkg::DIF_W'(cy_w) - csc_pkg::DIF_W'($signed(req.y2));
			r_q  <= req.r;
		end
	end

	// step decode: operands, shift and accumulate mode
	always_comb begin
		op_a     = '0;
		op_b     = '0;
		ctl_d    = '{vld: run_q, clr: 1'b0, sub: 1'b0, sh: SH_0, sv: SV_NONE,
			last: (step_q == S_M3)};
		case (step_q)
			S_RSQ: begin
				op_a = $signed({{(csc_pkg::MUL_W-csc_pkg::RAD_W){1'b0}}, r_q});
				op_b = op_a;
				ctl_d.clr = 1'b1;
				ctl_d.sv  = SV_RSQ;
			end
			S_CR0: begin
				op_a = sx(fx_q); op_b = sx(dy_q); ctl_d.clr = 1'b1;
			end
			S_CR1: begin
				op_a = sx(fy_q); op_b = sx(dx_q); ctl_d.sub = 1'b1; ctl_d.sv = SV_CR;
			end
			S_DD0: begin
				op_a = sx(dx_q); op_b = sx(dx_q); ctl_d.clr = 1'b1;
			end
			S_DD1: begin
				op_a = sx(dy_q); op_b = sx(dy_q); ctl_d.sv = SV_DD;
			end
			S_PP0: begin
				op_a = sx(fx_q); op_b = sx(dx_q); ctl_d.clr = 1'b1;
			end
			S_PP1: begin
				op_a = sx(fy_q); op_b = sx(dy_q); ctl_d.sv = SV_PP;
			end
			S_E10: begin
				op_a = sx(fx_q); op_b = sx(fx_q); ctl_d.clr = 1'b1;
			end
			S_E11: begin
				op_a = sx(fy_q); op_b = sx(fy_q); ctl_d.sv = SV_E1;
			end
			S_E20: begin
				op_a = sx(gx_q); op_b = sx(gx_q); ctl_d.clr = 1'b1;
			end
			S_E21: begin
				op_a = sx(gy_q); op_b = sx(gy_q); ctl_d.sv = SV_E2;
			end
			// cross^2 from a signed high limb and an unsigned low limb
			S_Q0: begin
				op_a = zl(cr_q[LW-1:0]); op_b = op_a; ctl_d.clr = 1'b1;
			end
			S_Q1, S_Q2: begin
				op_a = zl(cr_q[LW-1:0]);
				op_b = csc_pkg::MUL_W'($signed(cr_q[csc_pkg::CR_W-1:LW]));
				ctl_d.sh = SH_L;
			end
			S_Q3: begin
				op_a = csc_pkg::MUL_W'($signed(cr_q[csc_pkg::CR_W-1:LW]));
				op_b = op_a;
				ctl_d.sh = SH_2L;
			end
			// minus r^2 * |d|^2, scaled to the same fraction
			S_M0: begin
				op_a = zl(rsq_q[LW-1:0]); op_b = zl(dd_q[LW-1:0]);
				ctl_d.sub = 1'b1; ctl_d.sh = SH_F;
			end
			S_M1: begin
				op_a = zl(rsq_q[LW-1:0]);
				op_b = $signed({{(csc_pkg::MUL_W-csc_pkg::DDH_W){1'b0}},
					dd_q[csc_pkg::SQ_W-1:LW]});
				ctl_d.sub = 1'b1; ctl_d.sh = SH_LF;
			end
			S_M2: begin
				op_a = $signed({{(csc_pkg::MUL_W-csc_pkg::RSQH_W){1'b0}},
					rsq_q[csc_pkg::RSQ_W-1:LW]});
				op_b = zl(dd_q[LW-1:0]);
				ctl_d.sub = 1'b1; ctl_d.sh = SH_LF;
			end
			S_M3: begin
				op_a = $signed({{(csc_pkg::MUL_W-csc_pkg::RSQH_W){1'b0}},
					rsq_q[csc_pkg::RSQ_W-1:LW]});
				op_b = $signed({{(csc_pkg::MUL_W-csc_pkg::DDH_W){1'b0}},
					dd_q[csc_pkg::SQ_W-1:LW]});
				ctl_d.sub = 1'b1; ctl_d.sh = SH_2LF;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{vld: 1'b0, clr: 1'b0, sub: 1'b0, sh: SH_0, sv: SV_NONE, last: 1'b0};
			dec_q  <= 1'b0;
		end else begin
			ctl_s1 <= ctl_d;
			dec_q  <= ctl_s1.vld && ctl_s1.last;
		end
	end

	always_ff @(posedge clk)
		prod_s1 <= op_a * op_b;

	assign prod_ext = csc_pkg::ACC_W'(prod_s1);

	always_comb begin
		case (ctl_s1.sh)
			SH_0:    shifted = prod_ext;
			SH_L:    shifted = prod_ext <<< LW;
			SH_2L:   shifted = prod_ext <<< (2 * LW);
			SH_F:    shifted = prod_ext <<< F2;
			SH_LF:   shifted = prod_ext <<< (LW + F2);
			SH_2LF:  shifted = prod_ext <<< (2 * LW + F2);
			default: shifted = prod_ext;
		endcase
	end

	assign base  = ctl_s1.clr ? '0 : acc_q;
	assign acc_d = ctl_s1.sub ? (base - shifted) : (base + shifted);

	always_ff @(posedge clk) begin
		if (ctl_s1.vld) begin
			acc_q <= acc_d;
			case (ctl_s1.sv)
				SV_RSQ:  rsq_q <= acc_d[csc_pkg::RSQ_W-1:0];
				SV_CR:   cr_q  <= acc_d[csc_pkg::CR_W-1:0];
				SV_DD:   dd_q  <= acc_d[csc_pkg::SQ_W-1:0];
				SV_PP:   pp_q  <= acc_d[csc_pkg::PP_W-1:0];
				SV_E1:   e1_q  <= acc_d[csc_pkg::SQ_W-1:0];
				SV_E2:   e2_q  <= acc_d[csc_pkg::SQ_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp cases: zero-length or before the first end, past the second end, or in between
	assign r2       = {rsq_q, {F2{1'b0}}};
	assign dd_zero  = (dd_q == '0);
	assign pp_le0   = pp_q[csc_pkg::PP_W-1] || (pp_q == '0);
	assign dd_le_pp = ($signed({1'b0, dd_q}) <= pp_q);
	assign near1    = (CMP_W'(e1_q) <= CMP_W'(r2));
	assign near2    = (CMP_W'(e2_q) <= CMP_W'(r2));
	assign mid_ok   = acc_q[csc_pkg::ACC_W-1] || (acc_q == '0);

	assign res.valid = dec_q;
	assign res.hit   = (dd_zero || pp_le0) ? near1 : (dd_le_pp ? near2 : mid_ok);

endmodule

`default_nettype wire
